// File: hw/rtl/edmt_pkg.sv
// Shared types, microcode format and control ROM for the egg-drop minimum-trials block.
// Used by edmt_seq, edmt_dp and egg_drop_min_trials; depends on nothing else.

package edmt_pkg;

  localparam int EGG_W           = 5;
  localparam int FLOOR_W         = 7;
  localparam int TRIALS_W        = 7;
  localparam int EDMT_MAX_EGGS   = 16;
  localparam int EDMT_MAX_FLOORS = 64;

  // Input and result beats
  typedef struct packed {
    logic [EGG_W-1:0]   egg_count;
    logic [FLOOR_W-1:0] floor_count;
  } in_beat_t;

  typedef struct packed {
    logic [TRIALS_W-1:0] min_trials;
    logic                range_error;
  } out_beat_t;

  // Program steps: the step counter holds one of these
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_ROW0,
    ST_EINIT,
    ST_FINIT,
    ST_FTEST,
    ST_FSMALL,
    ST_KINIT,
    ST_KFIRST,
    ST_KLOOP,
    ST_FWR,
    ST_FNEXT,
    ST_ENEXT,
    ST_ANS,
    ST_OUT,
    ST_ERR
  } step_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WR_ROW0,
    OP_ROW_INIT,
    OP_F_CLR,
    OP_WR_FSMALL,
    OP_K_INIT,
    OP_K_FIRST,
    OP_K_LOOP,
    OP_WR_BEST,
    OP_F_INC,
    OP_E_NEXT,
    OP_RD_ANS,
    OP_OUT,
    OP_OUT_ERR
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_RANGE,
    C_F_NOT_LAST,
    C_E_ZERO,
    C_F_GE2,
    C_K_LE_F,
    C_E_NOT_LAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Status flags from the datapath for jump decisions
  typedef struct packed {
    logic range_bad;
    logic f_not_last;
    logic e_zero;
    logic f_ge2;
    logic k_le_f;
    logic e_not_last;
  } dp_stat_t;

  // Control store: one word per step; a taken condition jumps to target,
  // otherwise the step counter advances by one.
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      ST_IDLE:   w = '{op: OP_LOAD,      cond: C_NO_START,   target: ST_IDLE};
      ST_CHK:    w = '{op: OP_NONE,      cond: C_RANGE,      target: ST_ERR};
      ST_ROW0:   w = '{op: OP_WR_ROW0,   cond: C_F_NOT_LAST, target: ST_ROW0};
      ST_EINIT:  w = '{op: OP_ROW_INIT,  cond: C_E_ZERO,     target: ST_ANS};
      ST_FINIT:  w = '{op: OP_F_CLR,     cond: C_NEVER,      target: ST_IDLE};
      ST_FTEST:  w = '{op: OP_NONE,      cond: C_F_GE2,      target: ST_KINIT};
      ST_FSMALL: w = '{op: OP_WR_FSMALL, cond: C_ALWAYS,     target: ST_FNEXT};
      ST_KINIT:  w = '{op: OP_K_INIT,    cond: C_NEVER,      target: ST_IDLE};
      ST_KFIRST: w = '{op: OP_K_FIRST,   cond: C_NEVER,      target: ST_IDLE};
      ST_KLOOP:  w = '{op: OP_K_LOOP,    cond: C_K_LE_F,     target: ST_KLOOP};
      ST_FWR:    w = '{op: OP_WR_BEST,   cond: C_NEVER,      target: ST_IDLE};
      ST_FNEXT:  w = '{op: OP_F_INC,     cond: C_F_NOT_LAST, target: ST_FTEST};
      ST_ENEXT:  w = '{op: OP_E_NEXT,    cond: C_E_NOT_LAST, target: ST_FINIT};
      ST_ANS:    w = '{op: OP_RD_ANS,    cond: C_NEVER,      target: ST_IDLE};
      ST_OUT:    w = '{op: OP_OUT,       cond: C_ALWAYS,     target: ST_IDLE};
      ST_ERR:    w = '{op: OP_OUT_ERR,   cond: C_ALWAYS,     target: ST_IDLE};
      default:   w = '{op: OP_NONE,      cond: C_ALWAYS,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/edmt_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; no package needed.

module edmt_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 130
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re0,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic                     re1,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports; hold data when not enabled
  always_ff @(posedge clk) begin
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// File: hw/rtl/edmt_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on edmt_pkg for the step, operation and condition codes.

module edmt_seq
  import edmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output op_t      op,
  output logic     busy
);

  step_t  pc_r, pc_nxt;
  ucode_t word;
  logic   take;

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Fetch the control word, evaluate its condition, pick the next step
  always_comb begin
    word = ucode_rom(pc_r);
    case (word.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_START:   take = !start;
      C_RANGE:      take = stat.range_bad;
      C_F_NOT_LAST: take = stat.f_not_last;
      C_E_ZERO:     take = stat.e_zero;
      C_F_GE2:      take = stat.f_ge2;
      C_K_LE_F:     take = stat.k_le_f;
      C_E_NOT_LAST: take = stat.e_not_last;
      default:      take = 1'b0;
    endcase
    pc_nxt = take ? word.target : step_t'(pc_r + 4'd1);
    op     = word.op;
    busy   = (pc_r != ST_IDLE);
  end

endmodule

// File: hw/rtl/edmt_dp.sv
// Datapath: counters, min/max unit, two-row table RAM and result register.
// Depends on edmt_pkg and edmt_ram.

module edmt_dp
  import edmt_pkg::*;
#(
  parameter int MAX_EGGS   = EDMT_MAX_EGGS,
  parameter int MAX_FLOORS = EDMT_MAX_FLOORS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  op_t       op,
  input  in_beat_t  in_data,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_beat_t out_data
);

  localparam int ROW_LEN = MAX_FLOORS + 1;
  localparam int DEPTH   = 2 * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int FW      = $clog2(MAX_FLOORS + 2);

  // Map a row select and floor index onto a RAM address
  function automatic logic [AW-1:0] row_addr(input logic row, input logic [FW-1:0] idx);
    return row ? (AW'(ROW_LEN) + AW'(idx)) : AW'(idx);
  endfunction

  logic [EGG_W-1:0]    ne_r, ne_nxt, e_r, e_nxt;
  logic [FW-1:0]       nf_r, nf_nxt, f_r, f_nxt, k_r, k_nxt;
  logic [TRIALS_W:0]   best_r, best_nxt;
  logic                range_r, range_nxt;
  logic                cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;

  logic                we, re0, re1;
  logic [AW-1:0]       waddr, raddr0, raddr1;
  logic [TRIALS_W-1:0] wdata, rdata0, rdata1;
  logic [TRIALS_W:0]   trial;
  logic                range_bad_in;

  edmt_ram #(
    .WIDTH (TRIALS_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re0    (re0),
    .raddr0 (raddr0),
    .rdata0 (rdata0),
    .re1    (re1),
    .raddr1 (raddr1),
    .rdata1 (rdata1)
  );

  // Check the incoming beat against the built maximums
  assign range_bad_in = (32'(in_data.egg_count) > 32'(MAX_EGGS)) ||
                        (32'(in_data.floor_count) > 32'(MAX_FLOORS));

  // Cost of dropping at floor k: one more than the worse of the two outcomes
  assign trial = ((rdata0 > rdata1) ? {1'b0, rdata0} : {1'b0, rdata1}) + 1'b1;

  // Status for the sequencer
  assign stat.range_bad  = range_r;
  assign stat.f_not_last = (f_r != nf_r);
  assign stat.e_zero     = (ne_r == '0);
  assign stat.f_ge2      = (f_r >= FW'(2));
  assign stat.k_le_f     = (k_r <= f_r);
  assign stat.e_not_last = (e_r != ne_r);

  // Decode the operation into RAM strobes and next register values
  always_comb begin
    we            = 1'b0;
    waddr         = row_addr(cur_r, f_r);
    wdata         = TRIALS_W'(f_r);
    re0           = 1'b0;
    raddr0        = row_addr(!cur_r, k_r - FW'(1));
    re1           = 1'b0;
    raddr1        = row_addr(cur_r, f_r - k_r);
    ne_nxt        = ne_r;
    nf_nxt        = nf_r;
    range_nxt     = range_r;
    e_nxt         = e_r;
    f_nxt         = f_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (op)
      OP_LOAD: begin
        ne_nxt    = in_data.egg_count;
        nf_nxt    = FW'(in_data.floor_count);
        range_nxt = range_bad_in;
        f_nxt     = '0;
      end
      OP_WR_ROW0: begin
        we    = 1'b1;
        waddr = row_addr(1'b0, f_r);
        f_nxt = f_r + FW'(1);
      end
      OP_ROW_INIT: begin
        e_nxt   = EGG_W'(1);
        cur_nxt = 1'b1;
      end
      OP_F_CLR: begin
        f_nxt = '0;
      end
      OP_WR_FSMALL: begin
        we = 1'b1;
      end
      OP_K_INIT: begin
        k_nxt    = FW'(1);
        best_nxt = '1;
      end
      OP_K_FIRST: begin
        re0   = 1'b1;
        re1   = 1'b1;
        k_nxt = k_r + FW'(1);
      end
      OP_K_LOOP: begin
        // Fold in the previous read, issue the next while floors remain
        re0      = stat.k_le_f;
        re1      = stat.k_le_f;
        k_nxt    = k_r + FW'(1);
        best_nxt = (trial < best_r) ? trial : best_r;
      end
      OP_WR_BEST: begin
        we    = 1'b1;
        wdata = TRIALS_W'(best_r);
      end
      OP_F_INC: begin
        f_nxt = f_r + FW'(1);
      end
      OP_E_NEXT: begin
        e_nxt   = e_r + EGG_W'(1);
        cur_nxt = !cur_r;
      end
      OP_RD_ANS: begin
        re0    = 1'b1;
        raddr0 = row_addr(!cur_r, nf_r);
      end
      OP_OUT: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.min_trials  = rdata0;
        out_data_nxt.range_error = 1'b0;
      end
      OP_OUT_ERR: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.min_trials  = '0;
        out_data_nxt.range_error = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_r       <= 1'b0;
      e_r         <= '0;
      f_r         <= '0;
      k_r         <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      e_r         <= e_nxt;
      f_r         <= f_nxt;
      k_r         <= k_nxt;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    ne_r       <= ne_nxt;
    nf_r       <= nf_nxt;
    range_r    <= range_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/egg_drop_min_trials.sv
// Top level of the egg-drop minimum-trials block: sequencer plus datapath.
// Depends on edmt_pkg, edmt_seq and edmt_dp.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-----------------------------------
//   input    | start, busy, in_data     | beat taken when start && !busy
//   result   | out_valid, out_data      | one-cycle strobe, cannot be held
//
// An in-range beat fills the table row by row (nf floors, ne eggs) and then
// reads the answer; the inner loop handles one candidate floor per cycle,
// set by the single pair of table reads per cycle. An out-of-range beat
// goes from the check step straight to the error step, which issues the
// strobe with range_error set and zero trials.
// Reset returns the step counter to idle; the table needs no clearing pass.
// busy stays high from acceptance until the step that issues the result.

module egg_drop_min_trials
  import edmt_pkg::*;
#(
  parameter int MAX_EGGS   = EDMT_MAX_EGGS,
  parameter int MAX_FLOORS = EDMT_MAX_FLOORS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_valid,
  output out_beat_t out_data
);

  op_t      op;
  dp_stat_t stat;

  edmt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  edmt_dp #(
    .MAX_EGGS   (MAX_EGGS),
    .MAX_FLOORS (MAX_FLOORS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An accepted beat keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  // The result strobe appears only once the sequencer is back at idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // One strobe per beat
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // A range error carries zero trials
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |-> (out_data.min_trials == '0))
    else $error("range error with non-zero trials");
`endif

endmodule
